FILE: hdl/mtfwl_pkg.sv
// ----------------------------------------------------------------------------
// mtfwl_pkg
// Shared types, sizes and codes for the move-to-front window list.
// ----------------------------------------------------------------------------
`default_nettype none

package mtfwl_pkg;

  // Number of list slots.
  localparam int MAX_WINDOWS = 16;

  // Width of a slot index and of a count that can reach MAX_WINDOWS.
  localparam int IDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int CNT_W = $clog2(MAX_WINDOWS + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] count_t;
  typedef logic [7:0]       pos_t;
  typedef logic [4:0]       count_field_t;

  // Operation codes.
  typedef enum logic [2:0] {
    OP_CREATE   = 3'd0,
    OP_ACTIVATE = 3'd1,
    OP_RESIZE   = 3'd2,
    OP_REMOVE   = 3'd3,
    OP_READ     = 3'd4
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_POS = 2'd1,
    STATUS_FULL    = 2'd2
  } status_t;

  // Contents of one list entry.
  typedef struct packed {
    logic [7:0] color;
    logic [7:0] width;
    logic [7:0] height;
  } entry_t;

  // Update command from the control logic to the slot array.
  typedef struct packed {
    logic       wr;
    logic [2:0] op;
    idx_t       k;
    idx_t       tail;
    entry_t     data;
  } upd_t;

endpackage

`default_nettype wire

FILE: hdl/mtfwl_req_if.sv
// ----------------------------------------------------------------------------
// mtfwl_req_if
// Request channel of the window list: valid/ready handshake and operation.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtfwl_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] position;
  logic [7:0] color;
  logic [7:0] width;
  logic [7:0] height;

  modport source (output valid, op, position, color, width, height, input ready);
  modport sink   (input valid, op, position, color, width, height, output ready);
endinterface

`default_nettype wire

FILE: hdl/mtfwl_rsp_if.sv
// ----------------------------------------------------------------------------
// mtfwl_rsp_if
// Result channel of the window list: valid/ready handshake and result.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtfwl_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] entry_count;
  logic [7:0] entry_color;
  logic [7:0] entry_width;
  logic [7:0] entry_height;

  modport source (output valid, status, entry_count, entry_color, entry_width,
                  entry_height, input ready);
  modport sink   (input valid, status, entry_count, entry_color, entry_width,
                  entry_height, output ready);
endinterface

`default_nettype wire

FILE: hdl/mtfwl_slot_array.sv
// ----------------------------------------------------------------------------
// mtfwl_slot_array
// Register file of list slots, front at index 0, with per-slot next-value
// selection for append, move-to-front, resize and remove.
// ----------------------------------------------------------------------------
`default_nettype none

module mtfwl_slot_array (
  input  wire logic              clk,
  input  wire mtfwl_pkg::upd_t   upd,
  output      mtfwl_pkg::entry_t rd_entry
);

  mtfwl_pkg::entry_t slot_r [mtfwl_pkg::MAX_WINDOWS];
  mtfwl_pkg::entry_t slot_nxt [mtfwl_pkg::MAX_WINDOWS];

  // The entry at the addressed position, used by read and by move-to-front.
  assign rd_entry = slot_r[upd.k];

  // Each slot picks its next value from itself, a neighbor, the addressed entry or the request.
  for (genvar i = 0; i < mtfwl_pkg::MAX_WINDOWS; i++) begin : g_slot
    localparam mtfwl_pkg::idx_t I = mtfwl_pkg::idx_t'(i);

    always_comb begin
      slot_nxt[i] = slot_r[i];
      case (upd.op)
        mtfwl_pkg::OP_CREATE: begin
          if (upd.tail == I) begin
            slot_nxt[i] = upd.data;
          end
        end
        mtfwl_pkg::OP_ACTIVATE: begin
          if (i == 0) begin
            slot_nxt[i] = rd_entry;
          end else if (I <= upd.k) begin
            slot_nxt[i] = slot_r[(i > 0) ? i - 1 : 0];
          end
        end
        mtfwl_pkg::OP_RESIZE: begin
          if (upd.k == I) begin
            slot_nxt[i].width  = upd.data.width;
            slot_nxt[i].height = upd.data.height;
          end
        end
        mtfwl_pkg::OP_REMOVE: begin
          if (i < mtfwl_pkg::MAX_WINDOWS - 1 && I >= upd.k) begin
            slot_nxt[i] = slot_r[(i < mtfwl_pkg::MAX_WINDOWS - 1) ? i + 1 : i];
          end
        end
        default: begin
          slot_nxt[i] = slot_r[i];
        end
      endcase
    end

    // Slot contents carry no reset; they are defined once written.
    always_ff @(posedge clk) begin
      if (upd.wr) begin
        slot_r[i] <= slot_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/move_to_front_window_list.sv
// ----------------------------------------------------------------------------
// move_to_front_window_list
// Ordered list of window entries with create, move-to-front, resize, remove
// and read operations.
// ----------------------------------------------------------------------------
// The block takes one request per clock and returns one result per request:
// the request sits in the input register while the per-slot select logic works
// out its result, and the result register takes it once that register is empty
// or its result is taken. Every slot computes its next value in parallel, so a
// request sees the list as left by the request before it and the throughput
// stays at one request per cycle as long as the result side keeps taking
// results. Positions 0 and 1 both name the front entry; a position above the
// entry count returns an invalid position status, and create on a full list
// returns a full status.
// ----------------------------------------------------------------------------
`default_nettype none

module move_to_front_window_list (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mtfwl_req_if.sink   in_chan,
  mtfwl_rsp_if.source out_chan
);

  // Input register.
  logic              s1_valid_r;
  logic [2:0]        s1_op_r;
  mtfwl_pkg::pos_t   s1_pos_r;
  mtfwl_pkg::entry_t s1_data_r;

  // List count.
  mtfwl_pkg::count_t count_r;
  mtfwl_pkg::count_t count_nxt;

  // Result register.
  logic                    out_valid_r;
  mtfwl_pkg::status_t      status_r;
  mtfwl_pkg::count_field_t entry_count_r;
  mtfwl_pkg::entry_t       entry_r;

  logic                    out_adv;
  logic                    s1_fire;
  mtfwl_pkg::pos_t         k_full;
  logic                    pos_ok;
  logic                    full;
  logic                    wr;
  mtfwl_pkg::status_t      status_nxt;
  mtfwl_pkg::entry_t       entry_nxt;
  mtfwl_pkg::entry_t       rd_entry;
  mtfwl_pkg::upd_t         upd;

  // Handshake: the result register frees when empty or taken.
  assign out_adv       = !out_valid_r || out_chan.ready;
  assign s1_fire       = s1_valid_r && out_adv;
  assign in_chan.ready = !s1_valid_r || out_adv;

  // Position decode and range checks.
  assign k_full = (s1_pos_r <= 8'd1) ? 8'd0 : s1_pos_r - 8'd1;
  assign pos_ok = k_full < mtfwl_pkg::pos_t'(count_r);
  assign full   = count_r == mtfwl_pkg::count_t'(mtfwl_pkg::MAX_WINDOWS);

  // Operation decode: status, count and write enable.
  always_comb begin
    status_nxt = mtfwl_pkg::STATUS_OK;
    count_nxt  = count_r;
    entry_nxt  = '0;
    wr         = 1'b0;
    case (s1_op_r)
      mtfwl_pkg::OP_CREATE: begin
        if (full) begin
          status_nxt = mtfwl_pkg::STATUS_FULL;
        end else begin
          wr        = 1'b1;
          count_nxt = count_r + mtfwl_pkg::count_t'(1);
        end
      end
      mtfwl_pkg::OP_ACTIVATE, mtfwl_pkg::OP_RESIZE: begin
        if (!pos_ok) begin
          status_nxt = mtfwl_pkg::STATUS_BAD_POS;
        end else begin
          wr = 1'b1;
        end
      end
      mtfwl_pkg::OP_REMOVE: begin
        if (!pos_ok) begin
          status_nxt = mtfwl_pkg::STATUS_BAD_POS;
        end else begin
          wr        = 1'b1;
          count_nxt = count_r - mtfwl_pkg::count_t'(1);
        end
      end
      mtfwl_pkg::OP_READ: begin
        if (!pos_ok) begin
          status_nxt = mtfwl_pkg::STATUS_BAD_POS;
        end else begin
          entry_nxt = rd_entry;
        end
      end
      default: begin
        status_nxt = mtfwl_pkg::STATUS_OK;
      end
    endcase
  end

  // Update command for the slot array.
  assign upd.wr   = wr && s1_fire;
  assign upd.op   = s1_op_r;
  assign upd.k    = k_full[mtfwl_pkg::IDX_W-1:0];
  assign upd.tail = count_r[mtfwl_pkg::IDX_W-1:0];
  assign upd.data = s1_data_r;

  mtfwl_slot_array u_slots (
    .clk      (clk),
    .upd      (upd),
    .rd_entry (rd_entry)
  );

  // Control registers: request and result valid flags and the count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        count_r <= count_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_op_r          <= in_chan.op;
      s1_pos_r         <= in_chan.position;
      s1_data_r.color  <= in_chan.color;
      s1_data_r.width  <= in_chan.width;
      s1_data_r.height <= in_chan.height;
    end
    if (s1_fire) begin
      status_r      <= status_nxt;
      entry_count_r <= mtfwl_pkg::count_field_t'(count_nxt);
      entry_r       <= entry_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = status_r;
  assign out_chan.entry_count  = entry_count_r;
  assign out_chan.entry_color  = entry_r.color;
  assign out_chan.entry_width  = entry_r.width;
  assign out_chan.entry_height = entry_r.height;

  // The count never exceeds the number of slots.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= mtfwl_pkg::count_t'(mtfwl_pkg::MAX_WINDOWS))
    else $error("entry count above slot count");

  // The count only moves when a request passes into the result register.
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(count_r))
    else $error("entry count changed without a request");

  // A full status reports a full list.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == mtfwl_pkg::STATUS_FULL |->
      entry_count_r == mtfwl_pkg::count_field_t'(mtfwl_pkg::MAX_WINDOWS))
    else $error("full status with a list that is not full");

  // An empty input register takes a request even while the result stalls.
  a_skid: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_chan.ready)
    else $error("input stalled with an empty input register");

endmodule

`default_nettype wire
